// ----- sv/lirs_pkg.sv -----
// shared types and constants of the linear interpolation resampler
// field widths, register map indexes, controller states, datapath commands
// no dependencies
package lirs_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int RATE_W     = 19;
   localparam int LEN_W      = 24;
   localparam int DVS_W      = 20;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam int COUNT_WIDTH_DEF = 24;
   localparam int MAX_OUT_DEF     = 64;

   localparam logic [RATE_W-1:0] INPUT_RATE_RST  = 19'd16000;
   localparam logic [RATE_W-1:0] OUTPUT_RATE_RST = 19'd16000;
   localparam logic [LEN_W-1:0]  CLIP_LENGTH_RST = 24'd1;

   // register indexes, paddr[3:2]
   localparam logic [1:0] CSR_IDX_INPUT_RATE  = 2'd0;
   localparam logic [1:0] CSR_IDX_OUTPUT_RATE = 2'd1;
   localparam logic [1:0] CSR_IDX_CLIP_LENGTH = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PASS,
      ST_TGT_MUL,
      ST_TGT_GO,
      ST_TGT_WAIT,
      ST_STEP_GO,
      ST_STEP_WAIT,
      ST_END_MUL,
      ST_END_GO,
      ST_END_WAIT,
      ST_COUNT,
      ST_POS_MUL,
      ST_POS_GO,
      ST_POS_WAIT,
      ST_INT_MUL,
      ST_INT_GO,
      ST_INT_WAIT,
      ST_EMIT,
      ST_FINISH
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_EMIT_PASS,
      OP_MUL_TGT,
      OP_DIV_TGT,
      OP_SET_TGT,
      OP_DIV_STEP,
      OP_SET_STEP,
      OP_MUL_END,
      OP_DIV_END,
      OP_SET_END,
      OP_END_LAST,
      OP_COUNT,
      OP_MUL_POS,
      OP_DIV_POS,
      OP_SET_POS,
      OP_MUL_INT,
      OP_DIV_INT,
      OP_EMIT_INT,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      logic passthrough;
      logic first;
      logic last;
      logic div_done;
      logic none_due;
      logic run_end;
      logic out_free;
   } dp_status_type;

endpackage

// ----- sv/lirs_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on lirs_pkg for the divisor width
module lirs_div #(
   parameter int DVD_W = 45
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DVD_W-1:0]              dividend,
   input  logic [lirs_pkg::DVS_W-1:0]    divisor,
   output logic [DVD_W-1:0]              quotient,
   output logic [lirs_pkg::DVS_W-1:0]    remainder,
   output logic                          done
);
   import lirs_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DVD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

   // a new division drops the old result
   assert property (@(posedge clock) disable iff (reset) start |=> !done)
      else $error("divider reports done right after a start");

   // a finished result stays put until the next start
   assert property (@(posedge clock) disable iff (reset)
      done && !start |=> done && $stable(quotient) && $stable(remainder))
      else $error("divider result changed without a start");

endmodule

// ----- sv/lirs_dp.sv -----
// resampler datapath: clip state, shared multiplier, divider, output register
// depends on lirs_pkg and lirs_div
module lirs_dp #(
   parameter int COUNT_WIDTH           = lirs_pkg::COUNT_WIDTH_DEF,
   parameter int MAX_OUTPUTS_PER_INPUT = lirs_pkg::MAX_OUT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cfg_clear,
   input  logic [lirs_pkg::RATE_W-1:0]          input_rate,
   input  logic [lirs_pkg::RATE_W-1:0]          output_rate,
   input  logic [lirs_pkg::LEN_W-1:0]           clip_length,
   input  logic signed [lirs_pkg::SAMPLE_W-1:0] req_sample_in,
   input  lirs_pkg::dp_op_type                  op,
   input  logic                                 rsp_stall,
   output lirs_pkg::dp_status_type              status,
   output logic                                 rsp_valid,
   output logic signed [lirs_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                 rsp_run_last,
   output logic                                 rsp_clip_done,
   output logic                                 rsp_rate_overflow
);
   import lirs_pkg::*;

   localparam int CW     = COUNT_WIDTH;
   localparam int AW     = (CW > LEN_W) ? CW : LEN_W;
   localparam int PROD_W = AW + RATE_W;
   localparam int DVD_W  = AW + 21;
   localparam int IDX_W  = CW + RATE_W;
   localparam int EMIT_W = $clog2(MAX_OUTPUTS_PER_INPUT + 1);
   localparam int RUN_W  = EMIT_W + 1;
   localparam int CMP_W  = AW + 1;
   localparam int VAL_W  = SAMPLE_W + 3;
   localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

   // clip state
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [CW-1:0]              seen_ff, seen_in;
   logic [CW-1:0]              sent_ff, sent_in;
   logic [CW-1:0]              target_ff, target_in;
   // working registers
   logic signed [SAMPLE_W-1:0] cur_ff, cur_in;
   logic signed [SAMPLE_W-1:0] y0_ff, y0_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [CW-1:0]              nend_ff, nend_in;
   logic [RATE_W-1:0]          qstep_ff, qstep_in;
   logic [RATE_W-1:0]          rstep_ff, rstep_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [RATE_W-1:0]          ph_ff, ph_in;
   logic [EMIT_W-1:0]          emit_ff, emit_in;
   logic [EMIT_W-1:0]          cnt_ff, cnt_in;
   logic                       runov_ff, runov_in;
   logic                       neg_ff, neg_in;
   logic                       numneg_ff, numneg_in;
   // output register
   logic                       ovalid_ff, ovalid_in;
   logic signed [SAMPLE_W-1:0] osample_ff, osample_in;
   logic                       olast_ff, olast_in;
   logic                       odone_ff, odone_in;
   logic                       oov_ff, oov_in;

   // combinational helpers
   logic [LEN_W-1:0]    len_eff;
   logic                is_last;
   logic                passthrough;
   logic                same;
   logic [SAMPLE_W:0]   diff;
   logic [SAMPLE_W:0]   dval;
   logic [SAMPLE_W:0]   dmag;
   logic [AW-1:0]       mul_a;
   logic [RATE_W-1:0]   mul_b;
   logic [PROD_W-1:0]   mul_p;
   logic [DVD_W-1:0]    num;
   logic [DVD_W-1:0]    num_mag;
   logic [DVD_W-1:0]    div_dvd;
   logic [DVS_W-1:0]    div_dvs;
   logic                div_start;
   logic [DVD_W-1:0]    quo;
   logic [DVS_W-1:0]    rem;
   logic                div_done;
   logic [CW-1:0]       avail;
   logic                due;
   logic                run_ov;
   logic                run_end;
   logic                out_free;
   logic [17:0]         q_adj;
   logic [VAL_W-1:0]    q_val;
   logic [VAL_W-1:0]    v_sum;
   logic [RATE_W:0]     ph_sum;
   logic [RATE_W:0]     ph_wrapped;
   logic                wrap;

   always_comb begin
      len_eff     = (clip_length == '0) ? LEN_W'(1) : clip_length;
      is_last     = (CMP_W'(seen_ff) + CMP_W'(1)) >= CMP_W'(len_eff);
      passthrough = (input_rate == '0) || (output_rate == '0) ||
                    (input_rate == output_rate);
      same        = (idx_ff >= IDX_W'(seen_ff));
      diff        = {cur_ff[SAMPLE_W-1], cur_ff} - {prev_ff[SAMPLE_W-1], prev_ff};
      dval        = same ? '0 : diff;
      dmag        = dval[SAMPLE_W] ? (~dval + 1'b1) : dval;
      due         = (nend_ff > sent_ff);
      avail       = nend_ff - sent_ff;
      run_ov      = (avail > CW'(MAX_OUTPUTS_PER_INPUT));
      run_end     = (RUN_W'(cnt_ff) + RUN_W'(1)) == RUN_W'(emit_ff);
      out_free    = !ovalid_ff || !rsp_stall;
   end

   // shared multiplier, registered into prod_ff
   always_comb begin
      case (op)
         OP_MUL_TGT: begin
            mul_a = AW'(len_eff);
            mul_b = output_rate;
         end
         OP_MUL_END: begin
            mul_a = AW'(seen_ff);
            mul_b = output_rate;
         end
         OP_MUL_POS: begin
            mul_a = AW'(sent_ff);
            mul_b = input_rate;
         end
         default: begin
            mul_a = AW'(dmag);
            mul_b = ph_ff;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // rounding numerator 2*d*ph + out_rate, sign kept apart for the divider
   always_comb begin
      if (neg_ff) begin
         num = DVD_W'(output_rate) - DVD_W'({prod_ff, 1'b0});
      end else begin
         num = DVD_W'(output_rate) + DVD_W'({prod_ff, 1'b0});
      end
      num_mag = num[DVD_W-1] ? (~num + 1'b1) : num;
   end

   always_comb begin
      div_start = (op inside {OP_DIV_TGT, OP_DIV_STEP, OP_DIV_END, OP_DIV_POS,
                              OP_DIV_INT});
      case (op)
         OP_DIV_TGT: begin
            div_dvd = DVD_W'({prod_ff, 1'b0}) + DVD_W'(input_rate);
            div_dvs = {input_rate, 1'b0};
         end
         OP_DIV_STEP: begin
            div_dvd = DVD_W'(input_rate);
            div_dvs = DVS_W'(output_rate);
         end
         OP_DIV_END: begin
            div_dvd = DVD_W'(prod_ff) + DVD_W'(input_rate) - DVD_W'(1);
            div_dvs = DVS_W'(input_rate);
         end
         OP_DIV_POS: begin
            div_dvd = DVD_W'(prod_ff);
            div_dvs = DVS_W'(output_rate);
         end
         default: begin
            div_dvd = num_mag;
            div_dvs = {output_rate, 1'b0};
         end
      endcase
   end

   lirs_div #(
      .DVD_W (DVD_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .quotient  (quo),
      .remainder (rem),
      .done      (div_done)
   );

   // floor of the signed quotient, then add to the left neighbour
   always_comb begin
      q_adj  = quo[17:0] + 18'((numneg_ff && (rem != '0)) ? 1 : 0);
      q_val  = numneg_ff ? (~{1'b0, q_adj} + 1'b1) : {1'b0, q_adj};
      v_sum  = {{(VAL_W-SAMPLE_W){y0_ff[SAMPLE_W-1]}}, y0_ff} + q_val;
      ph_sum     = {1'b0, ph_ff} + {1'b0, rstep_ff};
      wrap       = (ph_sum >= {1'b0, output_rate});
      ph_wrapped = ph_sum - {1'b0, output_rate};
   end

   always_comb begin
      prev_in    = prev_ff;
      seen_in    = seen_ff;
      sent_in    = sent_ff;
      target_in  = target_ff;
      cur_in     = cur_ff;
      y0_in      = y0_ff;
      prod_in    = prod_ff;
      nend_in    = nend_ff;
      qstep_in   = qstep_ff;
      rstep_in   = rstep_ff;
      idx_in     = idx_ff;
      ph_in      = ph_ff;
      emit_in    = emit_ff;
      cnt_in     = cnt_ff;
      runov_in   = runov_ff;
      neg_in     = neg_ff;
      numneg_in  = numneg_ff;
      ovalid_in  = ovalid_ff && rsp_stall;
      osample_in = osample_ff;
      olast_in   = olast_ff;
      odone_in   = odone_ff;
      oov_in     = oov_ff;

      case (op)
         OP_CAPTURE: begin
            cur_in = req_sample_in;
         end
         OP_EMIT_PASS: begin
            ovalid_in  = 1'b1;
            osample_in = cur_ff;
            olast_in   = 1'b1;
            odone_in   = is_last;
            oov_in     = 1'b0;
            if (is_last) begin
               prev_in   = '0;
               seen_in   = '0;
               sent_in   = '0;
               target_in = '0;
               idx_in    = '0;
               ph_in     = '0;
            end else begin
               seen_in = seen_ff + CW'(1);
               prev_in = cur_ff;
            end
         end
         OP_MUL_TGT, OP_MUL_END, OP_MUL_POS: begin
            prod_in = mul_p;
         end
         OP_SET_TGT: begin
            if (quo > DVD_W'(COUNT_MAX)) begin
               target_in = COUNT_MAX;
            end else if (quo == '0) begin
               target_in = CW'(1);
            end else begin
               target_in = quo[CW-1:0];
            end
            sent_in = '0;
            idx_in  = '0;
            ph_in   = '0;
         end
         OP_SET_STEP: begin
            qstep_in = quo[RATE_W-1:0];
            rstep_in = rem[RATE_W-1:0];
         end
         OP_SET_END: begin
            nend_in = (quo > DVD_W'(target_ff)) ? target_ff : quo[CW-1:0];
         end
         OP_END_LAST: begin
            nend_in = target_ff;
         end
         OP_COUNT: begin
            runov_in = due && run_ov;
            if (!due) begin
               emit_in = '0;
            end else if (run_ov) begin
               emit_in = EMIT_W'(MAX_OUTPUTS_PER_INPUT);
            end else begin
               emit_in = avail[EMIT_W-1:0];
            end
         end
         OP_SET_POS: begin
            idx_in = quo[IDX_W-1:0];
            ph_in  = rem[RATE_W-1:0];
            cnt_in = '0;
         end
         OP_MUL_INT: begin
            prod_in = mul_p;
            neg_in  = dval[SAMPLE_W];
            y0_in   = same ? cur_ff : prev_ff;
         end
         OP_DIV_INT: begin
            numneg_in = num[DVD_W-1];
         end
         OP_EMIT_INT: begin
            ovalid_in  = 1'b1;
            osample_in = v_sum[SAMPLE_W-1:0];
            olast_in   = run_end;
            odone_in   = is_last && run_end;
            oov_in     = runov_ff;
            cnt_in     = cnt_ff + EMIT_W'(1);
            ph_in      = wrap ? ph_wrapped[RATE_W-1:0] : ph_sum[RATE_W-1:0];
            idx_in     = idx_ff + IDX_W'(qstep_ff) + IDX_W'(wrap);
         end
         OP_FINISH: begin
            if (is_last) begin
               prev_in   = '0;
               seen_in   = '0;
               sent_in   = '0;
               target_in = '0;
               idx_in    = '0;
               ph_in     = '0;
            end else begin
               if (due) begin
                  sent_in = nend_ff;
               end
               seen_in = seen_ff + CW'(1);
               prev_in = cur_ff;
            end
         end
         default: begin
         end
      endcase

      if (cfg_clear) begin
         prev_in   = '0;
         seen_in   = '0;
         sent_in   = '0;
         target_in = '0;
         idx_in    = '0;
         ph_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         seen_ff   <= '0;
         sent_ff   <= '0;
         target_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         prev_ff   <= prev_in;
         seen_ff   <= seen_in;
         sent_ff   <= sent_in;
         target_ff <= target_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      y0_ff      <= y0_in;
      prod_ff    <= prod_in;
      nend_ff    <= nend_in;
      qstep_ff   <= qstep_in;
      rstep_ff   <= rstep_in;
      idx_ff     <= idx_in;
      ph_ff      <= ph_in;
      emit_ff    <= emit_in;
      cnt_ff     <= cnt_in;
      runov_ff   <= runov_in;
      neg_ff     <= neg_in;
      numneg_ff  <= numneg_in;
      osample_ff <= osample_in;
      olast_ff   <= olast_in;
      odone_ff   <= odone_in;
      oov_ff     <= oov_in;
   end

   always_comb begin
      status.passthrough = passthrough;
      status.first       = (seen_ff == '0);
      status.last        = is_last;
      status.div_done    = div_done;
      status.none_due    = !due;
      status.run_end     = run_end;
      status.out_free    = out_free;
   end

   assign rsp_valid         = ovalid_ff;
   assign rsp_sample_out    = osample_ff;
   assign rsp_run_last      = olast_ff;
   assign rsp_clip_done     = odone_ff;
   assign rsp_rate_overflow = oov_ff;

endmodule

// ----- sv/lirs_ctrl.sv -----
// resampler sequencer: steps the datapath through each input transaction
// depends on lirs_pkg for states, commands and status
module lirs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  lirs_pkg::dp_status_type status,
   output logic                    req_stall,
   output lirs_pkg::dp_op_type     op
);
   import lirs_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.passthrough) begin
                  state_in = ST_PASS;
               end else if (status.first) begin
                  state_in = ST_TGT_MUL;
               end else begin
                  state_in = ST_END_MUL;
               end
            end
         end
         ST_PASS: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_TGT_MUL:  state_in = ST_TGT_GO;
         ST_TGT_GO:   state_in = ST_TGT_WAIT;
         ST_TGT_WAIT: begin
            if (status.div_done) begin
               state_in = ST_STEP_GO;
            end
         end
         ST_STEP_GO:  state_in = ST_STEP_WAIT;
         ST_STEP_WAIT: begin
            if (status.div_done) begin
               state_in = ST_END_MUL;
            end
         end
         ST_END_MUL:  state_in = status.last ? ST_COUNT : ST_END_GO;
         ST_END_GO:   state_in = ST_END_WAIT;
         ST_END_WAIT: begin
            if (status.div_done) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT:    state_in = status.none_due ? ST_FINISH : ST_POS_MUL;
         ST_POS_MUL:  state_in = ST_POS_GO;
         ST_POS_GO:   state_in = ST_POS_WAIT;
         ST_POS_WAIT: begin
            if (status.div_done) begin
               state_in = ST_INT_MUL;
            end
         end
         ST_INT_MUL:  state_in = ST_INT_GO;
         ST_INT_GO:   state_in = ST_INT_WAIT;
         ST_INT_WAIT: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.run_end ? ST_FINISH : ST_INT_MUL;
            end
         end
         ST_FINISH:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op        = OP_NONE;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE:      op = req_valid ? OP_CAPTURE : OP_NONE;
         ST_PASS:      op = status.out_free ? OP_EMIT_PASS : OP_NONE;
         ST_TGT_MUL:   op = OP_MUL_TGT;
         ST_TGT_GO:    op = OP_DIV_TGT;
         ST_TGT_WAIT:  op = status.div_done ? OP_SET_TGT : OP_NONE;
         ST_STEP_GO:   op = OP_DIV_STEP;
         ST_STEP_WAIT: op = status.div_done ? OP_SET_STEP : OP_NONE;
         ST_END_MUL:   op = status.last ? OP_END_LAST : OP_MUL_END;
         ST_END_GO:    op = OP_DIV_END;
         ST_END_WAIT:  op = status.div_done ? OP_SET_END : OP_NONE;
         ST_COUNT:     op = OP_COUNT;
         ST_POS_MUL:   op = OP_MUL_POS;
         ST_POS_GO:    op = OP_DIV_POS;
         ST_POS_WAIT:  op = status.div_done ? OP_SET_POS : OP_NONE;
         ST_INT_MUL:   op = OP_MUL_INT;
         ST_INT_GO:    op = OP_DIV_INT;
         ST_INT_WAIT:  op = OP_NONE;
         ST_EMIT:      op = status.out_free ? OP_EMIT_INT : OP_NONE;
         ST_FINISH:    op = OP_FINISH;
         default:      op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/linear_interp_resampler_unit.sv -----
// linear interpolation resampler, top level: apb register file, sequencer, datapath
// one input transaction at a time; a pass-through sample is sent straight on, an
// interpolated one gives none or more results, a clip's first sample also works out
// the target count and step, and a clip's last sample needs no end division; the shared
// one-bit-per-cycle divider serves all of these steps
// synchronous active-high reset: rates 16000/16000, clip length 1, clip state cleared
module linear_interp_resampler_unit #(
   parameter int COUNT_WIDTH           = lirs_pkg::COUNT_WIDTH_DEF,
   parameter int MAX_OUTPUTS_PER_INPUT = lirs_pkg::MAX_OUT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input samples
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [lirs_pkg::SAMPLE_W-1:0]   req_sample_in,
   // resampled output
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [lirs_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   output logic                                   rsp_run_last,
   output logic                                   rsp_clip_done,
   output logic                                   rsp_rate_overflow,
   // register port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [lirs_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [lirs_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [lirs_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);
   import lirs_pkg::*;

   // configuration registers
   logic [RATE_W-1:0] input_rate_ff, input_rate_in;
   logic [RATE_W-1:0] output_rate_ff, output_rate_in;
   logic [LEN_W-1:0]  clip_length_ff, clip_length_in;
   logic              csr_write;
   logic [1:0]        csr_idx;

   dp_status_type     status;
   dp_op_type         op;

   // pready is tied high, so the access phase never waits
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      input_rate_in  = input_rate_ff;
      output_rate_in = output_rate_ff;
      clip_length_in = clip_length_ff;
      if (csr_write) begin
         case (csr_idx)
            CSR_IDX_INPUT_RATE:  input_rate_in  = csr_pwdata[RATE_W-1:0];
            CSR_IDX_OUTPUT_RATE: output_rate_in = csr_pwdata[RATE_W-1:0];
            CSR_IDX_CLIP_LENGTH: clip_length_in = csr_pwdata[LEN_W-1:0];
            default: begin
               // unmapped address: the write still restarts the clip
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_IDX_INPUT_RATE:  csr_prdata = CSR_DATA_W'(input_rate_ff);
         CSR_IDX_OUTPUT_RATE: csr_prdata = CSR_DATA_W'(output_rate_ff);
         CSR_IDX_CLIP_LENGTH: csr_prdata = CSR_DATA_W'(clip_length_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         input_rate_ff  <= INPUT_RATE_RST;
         output_rate_ff <= OUTPUT_RATE_RST;
         clip_length_ff <= CLIP_LENGTH_RST;
      end else begin
         input_rate_ff  <= input_rate_in;
         output_rate_ff <= output_rate_in;
         clip_length_ff <= clip_length_in;
      end
   end

   // sequencer: one step per cycle while not waiting on the divider or the output
   lirs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .op        (op)
   );

   // datapath: any register write throws away the clip in progress
   lirs_dp #(
      .COUNT_WIDTH           (COUNT_WIDTH),
      .MAX_OUTPUTS_PER_INPUT (MAX_OUTPUTS_PER_INPUT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg_clear         (csr_write),
      .input_rate        (input_rate_ff),
      .output_rate       (output_rate_ff),
      .clip_length       (clip_length_ff),
      .req_sample_in     (req_sample_in),
      .op                (op),
      .rsp_stall         (rsp_stall),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_run_last      (rsp_run_last),
      .rsp_clip_done     (rsp_clip_done),
      .rsp_rate_overflow (rsp_rate_overflow)
   );

   // an accepted sample keeps the block busy for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again straight after a transaction");

   // the end of a clip is always the end of that sample's run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clip_done |-> rsp_run_last)
      else $error("clip end flagged on a result that is not last of its run");

   // results are only produced while a sample is being worked on
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while the block was idle");

endmodule
